@@ hdl/qoie_pkg.sv @@
`default_nettype none
package qoie_pkg;

  localparam int unsigned PixW     = 32;
  localparam int unsigned IdxDepth = 64;
  localparam int unsigned HashW    = $clog2(IdxDepth);

  localparam logic [31:0] PREV_INIT = 32'h0000_00ff;
  localparam logic [5:0]  RUN_MAX   = 6'd62;

  // chunk tags
  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hc0;
  localparam logic [7:0] OP_RGB   = 8'hfe;
  localparam logic [7:0] OP_RGBA  = 8'hff;

  // header and end marker
  localparam logic [7:0] MAGIC_Q    = 8'h71;
  localparam logic [7:0] MAGIC_O    = 8'h6f;
  localparam logic [7:0] MAGIC_I    = 8'h69;
  localparam logic [7:0] MAGIC_F    = 8'h66;
  localparam logic [7:0] CHANNELS   = 8'h04;
  localparam logic [7:0] END_LAST   = 8'h01;
  localparam logic [3:0] HDR_LAST   = 4'd13;
  localparam logic [3:0] END_CNT    = 4'd7;

  // configuration register indexes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [7:0] octet_t;

  // Everything one pixel puts on the byte stream, in emit order:
  // header, run flush, chunk, end marker.
  typedef struct packed {
    logic             hdr;
    logic [15:0]      width;
    logic [15:0]      height;
    logic             run;
    octet_t           run_byte;
    logic [2:0]       chunk_len;
    logic [4:0][7:0]  chunk;
    logic             eoi;
  } desc_t;

  function automatic logic [HashW-1:0] qoie_hash(input logic [PixW-1:0] px);
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
    logic [5:0] a;
    r = px[29:24];
    g = px[21:16];
    b = px[13:8];
    a = px[5:0];
    return (r * 6'd3) + (g * 6'd5) + (b * 6'd7) + (a * 6'd11);
  endfunction

endpackage
`default_nettype wire

@@ hdl/qoie_ram.sv @@
`default_nettype none
module qoie_ram #(
  parameter int unsigned DataW = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [DataW-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [DataW-1:0]         rdata
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/qoie_encode.sv @@
`default_nettype none
module qoie_encode import qoie_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire logic [PixW-1:0] in_pixel_rgba,
  input  wire logic [15:0]     cfg_width,
  input  wire logic [15:0]     cfg_height,
  input  wire logic [31:0]     pixel_total,
  output      logic            desc_valid,
  output      desc_t           desc,
  input  wire logic            desc_ready
);

  logic             s1_valid_r;
  logic [PixW-1:0]  s1_pix_r;
  logic [HashW-1:0] s1_hash_r;
  logic             fwd_hit_r;
  logic [PixW-1:0]  fwd_data_r;
  logic [PixW-1:0]  prev_r;
  logic [5:0]       run_r;
  logic [5:0]       run_nxt;
  logic [31:0]      seen_r;
  logic [IdxDepth-1:0] idx_valid_r;

  logic [PixW-1:0]  rd_data;
  logic [PixW-1:0]  entry;
  logic [HashW-1:0] in_hash;
  logic             accept;
  logic             s1_adv;
  logic             nonempty;
  logic             is_last;
  logic             same;
  logic             idx_we;
  logic [5:0]       run_inc;

  octet_t cr, cg, cb, ca, pr, pg, pb, pa;
  octet_t dr, dg, db, drg, dbg;
  octet_t dr2, dg2, db2, dg32, drg8, dbg8;

  assign in_hash  = qoie_hash(in_pixel_rgba);
  assign nonempty = desc.hdr || desc.run || (desc.chunk_len != 3'd0) || desc.eoi;
  assign s1_adv   = s1_valid_r && (!nonempty || desc_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;
  assign desc_valid = s1_valid_r && nonempty;

  qoie_ram #(
    .DataW (PixW),
    .Depth (IdxDepth)
  ) u_index (
    .clk   (clk),
    .we    (s1_adv && idx_we),
    .waddr (s1_hash_r),
    .wdata (s1_pix_r),
    .re    (accept),
    .raddr (in_hash),
    .rdata (rd_data)
  );

  always_comb begin
    cr = s1_pix_r[31:24];
    cg = s1_pix_r[23:16];
    cb = s1_pix_r[15:8];
    ca = s1_pix_r[7:0];
    pr = prev_r[31:24];
    pg = prev_r[23:16];
    pb = prev_r[15:8];
    pa = prev_r[7:0];
    dr  = cr - pr;
    dg  = cg - pg;
    db  = cb - pb;
    drg = dr - dg;
    dbg = db - dg;
    dr2  = dr + 8'd2;
    dg2  = dg + 8'd2;
    db2  = db + 8'd2;
    dg32 = dg + 8'd32;
    drg8 = drg + 8'd8;
    dbg8 = dbg + 8'd8;

    // a write to the same entry at the read edge is not seen by the RAM
    entry   = idx_valid_r[s1_hash_r] ? (fwd_hit_r ? fwd_data_r : rd_data) : '0;
    same    = (s1_pix_r == prev_r);
    is_last = ({1'b0, seen_r} + 33'd1) >= {1'b0, pixel_total};
    run_inc = run_r + 6'd1;

    desc.hdr       = (seen_r == 32'd0);
    desc.width     = cfg_width;
    desc.height    = cfg_height;
    desc.run       = 1'b0;
    desc.run_byte  = OP_RUN | {2'b00, run_r - 6'd1};
    desc.chunk_len = 3'd0;
    desc.chunk     = '0;
    desc.eoi       = is_last;
    idx_we         = 1'b0;
    run_nxt        = run_r;

    if (same) begin
      run_nxt = run_inc;
      if (run_inc == RUN_MAX || is_last) begin
        desc.run      = 1'b1;
        desc.run_byte = OP_RUN | {2'b00, run_r};
        run_nxt       = 6'd0;
      end
    end else begin
      run_nxt  = 6'd0;
      desc.run = (run_r != 6'd0);
      if (entry == s1_pix_r) begin
        desc.chunk_len = 3'd1;
        desc.chunk[0]  = OP_INDEX | {2'b00, s1_hash_r};
      end else begin
        idx_we = 1'b1;
        if (ca == pa) begin
          if ($signed(dr) > -8'sd3 && $signed(dr) < 8'sd2 &&
              $signed(dg) > -8'sd3 && $signed(dg) < 8'sd2 &&
              $signed(db) > -8'sd3 && $signed(db) < 8'sd2) begin
            desc.chunk_len = 3'd1;
            desc.chunk[0]  = OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
          end else if ($signed(dg) > -8'sd33 && $signed(dg) < 8'sd32 &&
                       $signed(drg) > -8'sd9 && $signed(drg) < 8'sd8 &&
                       $signed(dbg) > -8'sd9 && $signed(dbg) < 8'sd8) begin
            desc.chunk_len = 3'd2;
            desc.chunk[0]  = OP_LUMA | {2'b00, dg32[5:0]};
            desc.chunk[1]  = {drg8[3:0], dbg8[3:0]};
          end else begin
            desc.chunk_len = 3'd4;
            desc.chunk[0]  = OP_RGB;
            desc.chunk[1]  = cr;
            desc.chunk[2]  = cg;
            desc.chunk[3]  = cb;
          end
        end else begin
          desc.chunk_len = 3'd5;
          desc.chunk[0]  = OP_RGBA;
          desc.chunk[1]  = cr;
          desc.chunk[2]  = cg;
          desc.chunk[3]  = cb;
          desc.chunk[4]  = ca;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_pixel_rgba;
      s1_hash_r  <= in_hash;
      fwd_hit_r  <= s1_adv && idx_we && (s1_hash_r == in_hash);
      fwd_data_r <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= PREV_INIT;
      run_r       <= 6'd0;
      seen_r      <= 32'd0;
      idx_valid_r <= '0;
    end else if (s1_adv) begin
      if (is_last) begin
        prev_r      <= PREV_INIT;
        run_r       <= 6'd0;
        seen_r      <= 32'd0;
        idx_valid_r <= '0;
      end else begin
        prev_r <= s1_pix_r;
        run_r  <= run_nxt;
        seen_r <= seen_r + 32'd1;
        if (idx_we) begin
          idx_valid_r[s1_hash_r] <= 1'b1;
        end
      end
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_pix_r))
    else $error("pending pixel changed while waiting");

  a_index_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && is_last |=> idx_valid_r == '0 && seen_r == 32'd0)
    else $error("state not cleared after last pixel");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_r < RUN_MAX)
    else $error("run counter past flush limit");

endmodule
`default_nettype wire

@@ hdl/qoie_emit.sv @@
`default_nettype none
module qoie_emit import qoie_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        desc_valid,
  input  wire desc_t       desc,
  output      logic        desc_ready,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [7:0]  out_byte,
  output      logic        out_last_of_item,
  output      logic        out_end_of_image
);

  typedef enum logic [3:0] {
    PH_HDR = 4'b0001,
    PH_RUN = 4'b0010,
    PH_CHK = 4'b0100,
    PH_END = 4'b1000
  } phase_t;

  logic   busy_r;
  phase_t phase_r;
  phase_t phase_nxt;
  phase_t first_ph;
  logic [3:0] cnt_r;
  desc_t  d_r;

  logic   out_valid_r;
  octet_t out_byte_r;
  logic   out_last_r;
  logic   out_eoi_r;

  logic   fire;
  logic   ph_done;
  logic   more;
  logic   done;
  octet_t cur_byte;
  logic   load;

  function automatic octet_t hdr_byte(input logic [3:0] idx, input logic [15:0] w,
                                      input logic [15:0] h);
    octet_t v;
    case (idx)
      4'd0:                       v = MAGIC_Q;
      4'd1:                       v = MAGIC_O;
      4'd2:                       v = MAGIC_I;
      4'd3:                       v = MAGIC_F;
      4'd6:                       v = w[15:8];
      4'd7:                       v = w[7:0];
      4'd10:                      v = h[15:8];
      4'd11:                      v = h[7:0];
      4'd12:                      v = CHANNELS;
      default:                    v = 8'h00;
    endcase
    return v;
  endfunction

  always_comb begin
    if (desc.hdr) begin
      first_ph = PH_HDR;
    end else if (desc.run) begin
      first_ph = PH_RUN;
    end else if (desc.chunk_len != 3'd0) begin
      first_ph = PH_CHK;
    end else begin
      first_ph = PH_END;
    end
  end

  always_comb begin
    cur_byte  = 8'h00;
    ph_done   = 1'b1;
    more      = 1'b0;
    phase_nxt = PH_END;
    case (phase_r)
      PH_HDR: begin
        cur_byte = hdr_byte(cnt_r, d_r.width, d_r.height);
        ph_done  = (cnt_r == HDR_LAST);
        more     = d_r.run || (d_r.chunk_len != 3'd0) || d_r.eoi;
        if (d_r.run) begin
          phase_nxt = PH_RUN;
        end else if (d_r.chunk_len != 3'd0) begin
          phase_nxt = PH_CHK;
        end
      end
      PH_RUN: begin
        cur_byte = d_r.run_byte;
        more     = (d_r.chunk_len != 3'd0) || d_r.eoi;
        if (d_r.chunk_len != 3'd0) begin
          phase_nxt = PH_CHK;
        end
      end
      PH_CHK: begin
        case (cnt_r[2:0])
          3'd0:    cur_byte = d_r.chunk[0];
          3'd1:    cur_byte = d_r.chunk[1];
          3'd2:    cur_byte = d_r.chunk[2];
          3'd3:    cur_byte = d_r.chunk[3];
          3'd4:    cur_byte = d_r.chunk[4];
          default: cur_byte = 8'h00;
        endcase
        ph_done = ({1'b0, cnt_r[2:0]} + 4'd1) == {1'b0, d_r.chunk_len};
        more    = d_r.eoi;
      end
      PH_END: begin
        cur_byte = (cnt_r == END_CNT) ? END_LAST : 8'h00;
        ph_done  = (cnt_r == END_CNT);
      end
      default: begin
        cur_byte = 8'h00;
      end
    endcase
  end

  assign fire       = busy_r && (!out_valid_r || out_ready);
  assign done       = fire && ph_done && !more;
  assign desc_ready = !busy_r || done;
  assign load       = desc_valid && desc_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_END;
      cnt_r   <= 4'd0;
    end else if (load) begin
      busy_r  <= 1'b1;
      phase_r <= first_ph;
      cnt_r   <= 4'd0;
    end else if (fire) begin
      if (!ph_done) begin
        cnt_r <= cnt_r + 4'd1;
      end else if (more) begin
        phase_r <= phase_nxt;
        cnt_r   <= 4'd0;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r <= desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= cur_byte;
      out_last_r <= ph_done && !more;
      out_eoi_r  <= (phase_r == PH_END) && ph_done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last_of_item = out_last_r;
  assign out_end_of_image = out_eoi_r;

  a_eoi_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eoi_r |-> out_last_r)
    else $error("end of image byte not flagged last of item");

  a_hdr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && phase_r == PH_HDR |-> cnt_r <= HDR_LAST)
    else $error("header byte counter out of range");

  a_end_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && phase_r == PH_END |-> cnt_r <= END_CNT)
    else $error("end marker counter out of range");

endmodule
`default_nettype wire

@@ hdl/qoi_image_encoder_core.sv @@
// QOI image encoder core.
// Pixels enter on in_pixel_rgba (R 31:24, G 23:16, B 15:8, A 7:0) with
// in_valid/in_ready, in raster order. Encoded bytes leave on out_byte with
// out_valid/out_ready; out_last_of_item marks the final byte caused by a
// pixel and out_end_of_image the last byte of the end marker.
// image_width (0x0) and image_height (0x4) are set over the APB port; the
// user must set them only while the core is idle, which the core does not
// enforce. Their product sets the pixel count of an image. Throughput with
// out_ready high: one pixel per cycle for single-byte chunks and pixels that
// only extend a run; an RGBA chunk yields 5 bytes, the first pixel adds the
// 14-byte header and the last one the 8-byte end marker. The color index
// lives in a 64-entry RAM read at accept and written when the pixel leaves
// the pending stage, with same-entry forwarding. Reset sets the previous
// pixel to 0x000000ff, clears the run, pixel count and index valid bits and
// sets both dimensions to 1; the same state is reset once the last pixel
// leaves the pending stage. With out_ready low the output byte holds, the
// emitter and the pending pixel back up and in_ready drops.
`default_nettype none
module qoi_image_encoder_core import qoie_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [31:0] in_pixel_rgba,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [7:0]  out_byte,
  output      logic        out_last_of_item,
  output      logic        out_end_of_image,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [31:0] total_r;
  logic        wr_en;
  logic        desc_valid;
  logic        desc_ready;
  desc_t       desc;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {16'd0, height_r} : {16'd0, width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd1;
      height_r <= 16'd1;
      total_r  <= 32'd1;
    end else begin
      if (wr_en && paddr[2] == REG_WIDTH) begin
        width_r <= pwdata[15:0];
      end
      if (wr_en && paddr[2] == REG_HEIGHT) begin
        height_r <= pwdata[15:0];
      end
      total_r <= {16'd0, width_r} * {16'd0, height_r};
    end
  end

  qoie_encode u_encode (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_rgba (in_pixel_rgba),
    .cfg_width     (width_r),
    .cfg_height    (height_r),
    .pixel_total   (total_r),
    .desc_valid    (desc_valid),
    .desc          (desc),
    .desc_ready    (desc_ready)
  );

  qoie_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .desc_valid       (desc_valid),
    .desc             (desc),
    .desc_ready       (desc_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item),
    .out_end_of_image (out_end_of_image)
  );

endmodule
`default_nettype wire
